@@ design/bir_pkg.sv @@
package bir_pkg;

    // default sizes of the frame store and the step format
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 16;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int PIXEL_W  = 3 * SAMPLE_W;
    localparam int SIZE_W   = 9;
    localparam int STEP_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    // product of an 8-bit coordinate and a step
    localparam int POS_W    = 8 + STEP_W;
    // integer part of a source position, wide enough for the smallest fraction
    localparam int COORD_W  = POS_W - 8;
    // signed neighbour coordinate with room for the -1 and +2 offsets
    localparam int EXT_W    = COORD_W + 3;
    localparam int T_W      = 16;

    // kernel datapath widths
    localparam int P_W      = 18;
    localparam int A_W      = 24;
    localparam int H_W      = 48;
    localparam int MA_W     = 32;
    localparam int MB_W     = 28;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int U_W      = 25;
    localparam int Q_W      = 26;

    // floor division by three through a reciprocal, after a bias that keeps it positive
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP3      = ((1 << RECIP_SHIFT) + 2) / 3;
    localparam int DIV_BIAS    = 3 * (1 << 22);
    localparam int BIAS_DIV3   = 1 << 22;

    // queue between front and back
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_STEP_X     = 2'd2,
        CFG_STEP_Y     = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_REQUEST = 1'b1
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CALC,
        ST_DONE
    } back_state_t;

    // one classified beat on its way to the back end
    typedef struct packed {
        op_kind_t                kind;
        logic [SAMPLE_W-1:0]     row;
        logic [SAMPLE_W-1:0]     col;
        logic [PIXEL_W-1:0]      pixel;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic [T_W-1:0]          tx;
        logic [T_W-1:0]          ty;
    } op_t;

    // image size seen by the back end
    typedef struct packed {
        logic [SIZE_W-1:0] img_cols;
        logic [SIZE_W-1:0] img_rows;
    } cfg_t;

endpackage

@@ design/bir_ram.sv @@
module bir_ram
    import bir_pkg::*;
#(
    parameter int WIDTH = PIXEL_W,
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bir_front.sv @@
module bir_front
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  push,
    output op_t                   push_op,
    output cfg_t                  cfg
);

    localparam int DOWN_SH = (FRAC_BITS >= T_W) ? FRAC_BITS - T_W : 0;
    localparam int UP_SH   = (FRAC_BITS < T_W) ? T_W - FRAC_BITS : 0;

    logic [SIZE_W-1:0] img_cols_reg;
    logic [SIZE_W-1:0] img_rows_reg;
    logic [STEP_W-1:0] step_x_reg;
    logic [STEP_W-1:0] step_y_reg;

    logic [SAMPLE_W-1:0]  row;
    logic [SAMPLE_W-1:0]  col;
    logic [POS_W-1:0]     px;
    logic [POS_W-1:0]     py;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic                 in_store;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_cols_reg <= SIZE_W'(256);
            img_rows_reg <= SIZE_W'(256);
            step_x_reg   <= STEP_W'(131072);
            step_y_reg   <= STEP_W'(131072);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SRC_WIDTH:  img_cols_reg <= cfg_data[SIZE_W-1:0];
                CFG_SRC_HEIGHT: img_rows_reg <= cfg_data[SIZE_W-1:0];
                CFG_STEP_X:     step_x_reg   <= cfg_data[STEP_W-1:0];
                CFG_STEP_Y:     step_y_reg   <= cfg_data[STEP_W-1:0];
            endcase
        end
    end

    assign cfg.img_cols = img_cols_reg;
    assign cfg.img_rows = img_rows_reg;

    // source position of a request
    assign row = s_tdata[7:0];
    assign col = s_tdata[15:8];
    assign px  = POS_W'(col) * POS_W'(step_x_reg);
    assign py  = POS_W'(row) * POS_W'(step_y_reg);
    assign fx  = px[FRAC_BITS-1:0];
    assign fy  = py[FRAC_BITS-1:0];

    always_comb
    begin
        push_op.kind  = op_kind_t'(s_tuser);
        push_op.row   = row;
        push_op.col   = col;
        push_op.pixel = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
        push_op.x     = COORD_W'(px >> FRAC_BITS);
        push_op.y     = COORD_W'(py >> FRAC_BITS);
        if (FRAC_BITS >= T_W)
        begin
            push_op.tx = T_W'(fx >> DOWN_SH);
            push_op.ty = T_W'(fy >> DOWN_SH);
        end
        else
        begin
            push_op.tx = T_W'(POS_W'(fx) << UP_SH);
            push_op.ty = T_W'(POS_W'(fy) << UP_SH);
        end
    end

    // writes outside the store are dropped here
    assign in_store = (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready && (s_tuser || in_store);

endmodule

@@ design/bir_queue.sv @@
module bir_queue
    import bir_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head,
    output logic full,
    output logic empty
);

    op_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ design/bir_back.sv @@
module bir_back
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  op_t                head,
    input  logic               empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [PIXEL_W-1:0] m_tdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RIW   = $clog2(MAX_HEIGHT);
    localparam int CIW   = $clog2(MAX_WIDTH);

    back_state_t state_reg, state_next;

    logic [4:0] k_reg, k_next;
    logic [2:0] s_reg, s_next;
    logic [2:0] j_reg, j_next;
    logic [1:0] ch_reg, ch_next;

    logic signed [EXT_W-1:0] x_reg;
    logic signed [EXT_W-1:0] y_reg;
    logic [T_W-1:0]          tx_reg;
    logic [T_W-1:0]          ty_reg;
    logic [PIXEL_W-1:0]      pix_reg [16];
    logic signed [P_W-1:0]   rows_reg [4];
    logic [SAMPLE_W-1:0]     res_reg [3];
    logic signed [H_W-1:0]   h_reg;
    logic [31:0]             plo_reg;
    logic [U_W-1:0]          u_reg;
    logic                    inside_reg;
    logic                    out_valid_reg;
    logic [PIXEL_W-1:0]      out_data_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [PIXEL_W-1:0]      ram_wdata;
    logic [PIXEL_W-1:0]      ram_rdata;

    logic signed [EXT_W-1:0] nb_r;
    logic signed [EXT_W-1:0] nb_c;
    logic                    nb_inside;
    logic [SIZE_W-1:0]       w_eff;
    logic [SIZE_W-1:0]       h_eff;

    logic                    row_pass;
    logic signed [P_W-1:0]   p [4];
    logic [T_W-1:0]          t;
    logic signed [A_W-1:0]   d0, d2, d3, a1, a2, a3;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [16:0]             rnd;
    logic signed [H_W-1:0]   scaled;
    logic signed [Q_W-1:0]   quot;
    logic                    load_out;
    logic                    calc_last;

    bir_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // image size limited to the store
    assign w_eff = (32'(cfg.img_cols) < MAX_WIDTH) ? cfg.img_cols : SIZE_W'(MAX_WIDTH);
    assign h_eff = (32'(cfg.img_rows) < MAX_HEIGHT) ? cfg.img_rows : SIZE_W'(MAX_HEIGHT);

    // neighbour of the current fetch slot
    assign nb_r = y_reg - EXT_W'(1) + EXT_W'(k_reg[3:2]);
    assign nb_c = x_reg - EXT_W'(1) + EXT_W'(k_reg[1:0]);
    assign nb_inside = !nb_r[EXT_W-1] && !nb_c[EXT_W-1]
                    && (nb_r < $signed(EXT_W'(h_eff)))
                    && (nb_c < $signed(EXT_W'(w_eff)));

    // kernel operands: a row of samples or the four row results
    assign row_pass = (j_reg != 3'd4);
    assign t        = row_pass ? tx_reg : ty_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (row_pass)
            begin
                unique case (ch_reg)
                    2'd0:    p[i] = $signed(P_W'(pix_reg[i][23:16]));
                    2'd1:    p[i] = $signed(P_W'(pix_reg[i][15:8]));
                    2'd2:    p[i] = $signed(P_W'(pix_reg[i][7:0]));
                    default: p[i] = '0;
                endcase
            end
            else
            begin
                p[i] = rows_reg[i];
            end
        end
    end

    assign d0 = A_W'(p[0]) - A_W'(p[1]);
    assign d2 = A_W'(p[2]) - A_W'(p[1]);
    assign d3 = A_W'(p[3]) - A_W'(p[1]);
    assign a1 = d2 * A_W'(6) - d0 * A_W'(2) - d3;
    assign a2 = d0 * A_W'(3) + d2 * A_W'(3);
    assign a3 = d3 - d0 - d2 * A_W'(3);

    // shared multiplier, one product per step
    always_comb
    begin
        mul_a = '0;
        mul_b = $signed(MB_W'(t));
        unique case (s_reg)
            3'd0:       mul_a = MA_W'(a3);
            3'd1, 3'd3: mul_a = $signed(MA_W'(h_reg[15:0]));
            3'd2, 3'd4: mul_a = MA_W'(h_reg >>> 16);
            3'd6:
            begin
                mul_a = $signed(MA_W'(RECIP3));
                mul_b = $signed(MB_W'(u_reg));
            end
            default:    mul_a = '0;
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign rnd    = 17'((33'(plo_reg) + 33'd32768) >> 16);
    assign scaled = row_pass ? ((h_reg + H_W'(768)) >>> 9)
                             : ((h_reg + H_W'(3 * (1 << 24))) >>> 25);
    assign quot   = $signed(prod[RECIP_SHIFT+U_W:RECIP_SHIFT]) - Q_W'(BIAS_DIV3);

    assign calc_last = (s_reg == 3'd6) && !row_pass && (ch_reg == 2'd2);
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty && head.kind == OP_REQUEST)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (k_reg == 5'd16)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (calc_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // outputs and counters
    always_comb
    begin
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = head.pixel;
        ram_addr  = AW'(32'(head.row) * MAX_WIDTH + 32'(head.col));
        k_next    = k_reg;
        s_next    = s_reg;
        j_next    = j_reg;
        ch_next   = ch_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop    = !empty;
                ram_we = !empty && (head.kind == OP_WRITE);
                k_next = '0;
                s_next = '0;
                j_next = '0;
                ch_next = '0;
            end
            ST_FETCH:
            begin
                ram_addr = AW'(32'(nb_r[RIW-1:0]) * MAX_WIDTH + 32'(nb_c[CIW-1:0]));
                k_next   = k_reg + 5'd1;
            end
            ST_CALC:
            begin
                if (s_reg == 3'd6)
                begin
                    s_next = '0;
                    if (row_pass)
                    begin
                        j_next = j_reg + 3'd1;
                    end
                    else
                    begin
                        j_next  = '0;
                        ch_next = ch_reg + 2'd1;
                    end
                end
                else
                begin
                    s_next = s_reg + 3'd1;
                end
            end
            ST_DONE:
            begin
                k_next = k_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            s_reg         <= '0;
            j_reg         <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            s_reg     <= s_next;
            j_reg     <= j_next;
            ch_reg    <= ch_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && !empty && head.kind == OP_REQUEST)
        begin
            x_reg  <= $signed(EXT_W'(head.x));
            y_reg  <= $signed(EXT_W'(head.y));
            tx_reg <= head.tx;
            ty_reg <= head.ty;
        end
        if (state_reg == ST_FETCH)
        begin
            inside_reg <= nb_inside;
            if (k_reg != 5'd0)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    pix_reg[i] <= pix_reg[i+1];
                end
                pix_reg[15] <= inside_reg ? ram_rdata : '0;
            end
        end
        if (state_reg == ST_CALC)
        begin
            unique case (s_reg)
                3'd0:       h_reg <= H_W'(prod) + (H_W'(a2) <<< 16);
                3'd1, 3'd3: plo_reg <= prod[31:0];
                3'd2:       h_reg <= H_W'(prod) + $signed(H_W'(rnd)) + (H_W'(a1) <<< 16);
                3'd4:       h_reg <= H_W'(prod) + $signed(H_W'(rnd))
                                   + (H_W'(p[1]) * 6 <<< 16);
                3'd5:       u_reg <= U_W'(scaled + H_W'(DIV_BIAS));
                3'd6:
                begin
                    if (row_pass)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            rows_reg[i] <= rows_reg[i+1];
                        end
                        rows_reg[3] <= P_W'(quot);
                        // bring the next row of the window to the front
                        for (int i = 0; i < 16; i++)
                        begin
                            pix_reg[i] <= pix_reg[(i + 4) % 16];
                        end
                    end
                    else
                    begin
                        if (quot < 0)
                        begin
                            res_reg[ch_reg] <= '0;
                        end
                        else if (quot > 255)
                        begin
                            res_reg[ch_reg] <= 8'd255;
                        end
                        else
                        begin
                            res_reg[ch_reg] <= quot[7:0];
                        end
                    end
                end
                default:    u_reg <= u_reg;
            endcase
        end
        if (load_out)
        begin
            out_data_reg <= {res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ design/bicubic_image_resampler.sv @@
// Bicubic image resampler with an on-chip RGB frame store.
// Input stream: each beat is either a pixel write (tuser 0) that stores one
// source pixel at row/col, or a request (tuser 1) for the output pixel at
// row/col. Writes outside the store are dropped; writes give no result.
// Output stream: one beat per request with the rounded, clamped samples.
// Configuration channel sets image width/height and the Q.FRAC_BITS steps;
// write it only while no request is in flight.
// A front end maps requests to source positions and feeds a two-entry queue;
// the back end executes writes straight from the queue head; a request reads
// the 4x4 window (one word per cycle from the single-port store), then runs
// 15 kernel evaluations on one shared multiplier, then loads the output
// register, and the next queue entry waits until it is done.
// Sustained rate: one write per cycle while no request occupies the back end.
// While a result waits for m_tready the front still accepts beats until the
// queue fills; the back end holds its finished result until the output
// register frees up. Reset clears control state and restores the default
// configuration; the frame store keeps no reset value and must be written
// before it is read.
module bicubic_image_resampler
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // row, col, in_red, in_green, in_blue
    input  logic [39:0]           s_tdata,
    // cmd
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_red, out_green, out_blue
    output logic [23:0]           m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic push;
    op_t  push_op;
    logic pop;
    op_t  head;
    logic q_full;
    logic q_empty;
    cfg_t cfg;

    bir_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op),
        .cfg       (cfg)
    );

    bir_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    bir_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ tb/sv/bir_checker.sv @@
module bir_checker
    import bir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [39:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    pixels_stored,
    output int                    pixels_checked
);

    // shadow of the frame store, red 23..16, green 15..8, blue 7..0
    logic [PIXEL_W-1:0] shadow_store [0:65535];
    logic [SIZE_W-1:0]  img_w;
    logic [SIZE_W-1:0]  img_h;
    logic [STEP_W-1:0]  stp_x;
    logic [STEP_W-1:0]  stp_y;

    // expected output beats, red in the low byte as on m_tdata
    logic [23:0] expected_pixels [$];

    // floor((n + d/2) / d)
    function automatic longint round_div(longint n, longint d);
        longint m;
        longint q;
        m = n + d / 2;
        q = m / d;
        if (m % d != 0 && m < 0)
            q--;
        return q;
    endfunction

    // cubic kernel, result scaled by 6 * 65536
    function automatic longint cubic6(longint pm, longint p0, longint p1, longint p2,
                                      longint t);
        longint d0, d2, d3, a1, a2, a3, h;
        d0 = pm - p0;
        d2 = p1 - p0;
        d3 = p2 - p0;
        a1 = -2 * d0 + 6 * d2 - d3;
        a2 = 3 * d0 + 3 * d2;
        a3 = -d0 - 3 * d2 + d3;
        h = a3 * t + a2 * 65536;
        h = round_div(h * t, 65536) + a1 * 65536;
        h = round_div(h * t, 65536) + 6 * p0 * 65536;
        return h;
    endfunction

    // neighbour sample, zero outside the image
    function automatic longint neighbour(longint r, longint c, longint w, longint h,
                                         int shift);
        logic [PIXEL_W-1:0] word;
        if (r < 0 || c < 0 || r >= h || c >= w)
            return 0;
        word = shadow_store[r * 256 + c];
        return longint'((word >> shift) & 8'hFF);
    endfunction

    function automatic logic [23:0] resample(logic [7:0] orow, logic [7:0] ocol);
        longint w, h, px, py, x, y, tx, ty, v;
        longint rows [4];
        longint p [4];
        logic [23:0] res;
        w = (img_w < 256) ? longint'(img_w) : 256;
        h = (img_h < 256) ? longint'(img_h) : 256;
        px = longint'(ocol) * longint'(stp_x);
        py = longint'(orow) * longint'(stp_y);
        x = px >>> 16;
        y = py >>> 16;
        tx = px & 65535;
        ty = py & 65535;
        res = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int jj = 0; jj < 4; jj++)
            begin
                for (int k = 0; k < 4; k++)
                    p[k] = neighbour(y - 1 + jj, x - 1 + k, w, h, 16 - 8 * ch);
                rows[jj] = round_div(cubic6(p[0], p[1], p[2], p[3], tx), 6 * 256);
            end
            v = round_div(cubic6(rows[0], rows[1], rows[2], rows[3], ty), 64'd100663296);
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            res[8*ch +: 8] = v[7:0];
        end
        return res;
    endfunction

    task automatic report(string what, int expv, int gotv);
        $display("MISMATCH %s: expected %0d, got %0d", what, expv, gotv);
        fail_count++;
    endtask

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w  <= 9'd256;
            img_h  <= 9'd256;
            stp_x  <= 24'd131072;
            stp_y  <= 24'd131072;
            expected_pixels.delete();
            fail_count = 0;
            pending = 0;
            pixels_stored = 0;
            pixels_checked = 0;
        end
        else
        begin
            // configuration beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SRC_WIDTH:  img_w <= cfg_data[SIZE_W-1:0];
                    CFG_SRC_HEIGHT: img_h <= cfg_data[SIZE_W-1:0];
                    CFG_STEP_X:     stp_x <= cfg_data;
                    CFG_STEP_Y:     stp_y <= cfg_data;
                    default: ;
                endcase
            end
            // input beat
            if (s_tvalid && s_tready)
            begin
                if (op_kind_t'(s_tuser) == OP_WRITE)
                begin
                    shadow_store[{s_tdata[7:0], s_tdata[15:8]}] <=
                        {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
                    pixels_stored++;
                end
                else
                    expected_pixels.push_back(resample(s_tdata[7:0], s_tdata[15:8]));
            end
            // output beat
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                    report("unexpected output beat", 0, 1);
                else
                begin
                    logic [23:0] exp_px;
                    exp_px = expected_pixels.pop_front();
                    if (m_tdata[7:0] != exp_px[7:0])
                        report("out_red", exp_px[7:0], m_tdata[7:0]);
                    if (m_tdata[15:8] != exp_px[15:8])
                        report("out_green", exp_px[15:8], m_tdata[15:8]);
                    if (m_tdata[23:16] != exp_px[23:16])
                        report("out_blue", exp_px[23:16], m_tdata[23:16]);
                    pixels_checked++;
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

@@ tb/sv/bicubic_image_resampler_tb.sv @@
module bicubic_image_resampler_tb;
    import bir_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int FILL_SIDE   = 12;
    localparam int NUM_PHASES  = 8;
    localparam int RAND_ITEMS  = 140;
    localparam int HOLD_CYCLES = 700;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int pixels_stored;
    int pixels_checked;
    int cycle_count = 0;
    int idle_pct;
    logic hold_go;
    logic hold_done = 1'b0;
    int hold_left = 0;

    // stimulus view of the image: which entries hold data, and the settings
    bit pixel_written [0:65535];
    int cur_w;
    int cur_h;
    int cur_sx;
    int cur_sy;

    // width, height, step_x, step_y per phase; phase 0 keeps the reset values
    int phase_w  [NUM_PHASES] = '{256, 16, 1, 256, 0, 511, 5, 256};
    int phase_h  [NUM_PHASES] = '{256, 16, 256, 1, 300, 511, 7, 256};
    int phase_sx [NUM_PHASES] = '{131072, 65536, 49152, 16777215, 0, 0, 98304, 131072};
    int phase_sy [NUM_PHASES] = '{131072, 65536, 1, 32768, 16777215, 0, 81920, 131072};

    bicubic_image_resampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bir_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_stored  (pixels_stored),
        .pixels_checked (pixels_checked)
    );

    // clock
    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // every stored neighbour that the request would read has been written
    function automatic bit window_defined(int orow, int ocol);
        longint w, h, x, y, r, c;
        w = (cur_w < 256) ? cur_w : 256;
        h = (cur_h < 256) ? cur_h : 256;
        x = (longint'(ocol) * longint'(cur_sx)) >>> 16;
        y = (longint'(orow) * longint'(cur_sy)) >>> 16;
        for (int jj = 0; jj < 4; jj++)
            for (int k = 0; k < 4; k++)
            begin
                r = y - 1 + jj;
                c = x - 1 + k;
                if (r >= 0 && c >= 0 && r < h && c < w && !pixel_written[r * 256 + c])
                    return 1'b0;
            end
        return 1'b1;
    endfunction

    // one input beat, valid left high after acceptance
    task automatic send_beat(op_kind_t kind, int r, int c, int red, int green, int blue);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {blue[7:0], green[7:0], red[7:0], c[7:0], r[7:0]};
        if (kind == OP_WRITE)
            pixel_written[r * 256 + c] = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic store_pixel(int r, int c);
        send_beat(OP_WRITE, r, c, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
    endtask

    task automatic request_pixel(int r, int c);
        send_beat(OP_REQUEST, r, c, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
    endtask

    // random request where the window is defined, tried in half the calls; otherwise a write
    task automatic random_item();
        int r, c;
        if ($urandom_range(0, 99) < 50)
        begin
            for (int tries = 0; tries < 8; tries++)
            begin
                if ($urandom_range(0, 1))
                begin
                    r = $urandom_range(0, 7);
                    c = $urandom_range(0, 7);
                end
                else
                begin
                    r = $urandom_range(0, 255);
                    c = $urandom_range(0, 255);
                end
                if (window_defined(r, c))
                begin
                    request_pixel(r, c);
                    return;
                end
            end
        end
        if ($urandom_range(0, 99) < 70)
            store_pixel($urandom_range(0, 15), $urandom_range(0, 15));
        else
            store_pixel($urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // one configuration write, valid left high after acceptance
    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // drain all results, then let trailing writes finish
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    initial
    begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SRC_WIDTH;
        cfg_data  <= '0;
        hold_go   = 1'b0;
        idle_pct = 21;
        cur_w = 256;
        cur_h = 256;
        cur_sx = 131072;
        cur_sy = 131072;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // new settings while idle
            if (ph > 0)
            begin
                drain();
                cur_w  = phase_w[ph];
                cur_h  = phase_h[ph];
                cur_sx = phase_sx[ph];
                cur_sy = phase_sy[ph];
                write_reg(CFG_SRC_WIDTH, cur_w);
                write_reg(CFG_SRC_HEIGHT, cur_h);
                write_reg(CFG_STEP_X, cur_sx);
                write_reg(CFG_STEP_Y, cur_sy);
                cfg_valid <= 1'b0;
                @(posedge clk);
            end

            // fill the top-left corner of the image
            for (int r = 0; r < FILL_SIDE && r < cur_h; r++)
                for (int c = 0; c < FILL_SIDE && c < cur_w; c++)
                    store_pixel(r, c);

            // directed corner cases
            if (ph == 0)
            begin
                send_beat(OP_WRITE, 0, 0, 0, 0, 0);
                send_beat(OP_WRITE, 1, 1, 255, 255, 255);
                send_beat(OP_WRITE, 255, 255, 255, 255, 255);
                send_beat(OP_WRITE, 2, 2, 255, 0, 255);
                request_pixel(0, 0);
                request_pixel(1, 1);
                request_pixel(0, 1);
                request_pixel(255, 255);
                request_pixel(2, 3);
                request_pixel(3, 0);
            end
            else
            begin
                request_pixel(0, 0);
                request_pixel(255, 255);
                if (window_defined(0, 255))
                    request_pixel(0, 255);
                if (window_defined(255, 0))
                    request_pixel(255, 0);
            end

            // random traffic; one phase without any stalls, one with a long hold-off
            idle_pct = (ph == 2) ? 0 : 21;
            if (ph == 1)
                hold_go = 1'b1;
            for (int i = 0; i < RAND_ITEMS; i++)
                random_item();
            idle_pct = 21;
        end

        drain();
        $display("covered %0d pixel writes and %0d checked output pixels", pixels_stored,
                 pixels_checked);
        $display("across %0d settings of image size and step ratio", NUM_PHASES);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
